>>> rtl/efd_pkg.sv
`default_nettype none
package efd_pkg;

  localparam int unsigned TableDepthDefault    = 64;
  localparam int unsigned CleanupPeriodDefault = 10;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgConfThr  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMinLat   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLat   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgDupWin   = 8'd3;

  localparam logic [2:0] InstrKick  = 3'd0;
  localparam logic [2:0] InstrSnare = 3'd1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic frame;
    logic div_init;
    logic div_step;
    logic idx_clr;
    logic idx_inc;
    logic rd;
    logic cmp_hit;
    logic cmp_sweep;
    logic decide;
  } efd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_hit;
    logic sweep_due;
    logic pass;
    logic idx_last;
  } efd_sts_t;

endpackage
`default_nettype wire

>>> rtl/efd_ctrl.sv
`default_nettype none
module efd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire efd_pkg::efd_sts_t sts_i,
  output efd_pkg::efd_cmd_t     cmd_o,
  output logic                  busy_o
);
  import efd_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StRead   = 3'd3;
  localparam logic [2:0] StCmp    = 3'd4;
  localparam logic [2:0] StDecide = 3'd5;
  localparam logic [2:0] StSwRead = 3'd6;
  localparam logic [2:0] StSwCmp  = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy_o = (state_q != StIdle);

  // sequence one item: a frame start and its periodic sweep, or a hit through filter, key divide, table scan and update
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (!sts_i.is_hit) begin
          cmd_o.frame = 1'b1;
          if (sts_i.sweep_due) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = StSwRead;
          end else begin
            state_d = StIdle;
          end
        end else if (sts_i.pass) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        state_d        = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StCmp;
      end
      StCmp: begin
        cmd_o.cmp_hit = 1'b1;
        if (sts_i.idx_last) begin
          state_d = StDecide;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = StRead;
        end
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = StIdle;
      end
      StSwRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StSwCmp;
      end
      StSwCmp: begin
        cmd_o.cmp_sweep = 1'b1;
        if (sts_i.idx_last) begin
          state_d = StIdle;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = StSwRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/efd_dp.sv
`default_nettype none
module efd_dp #(
  parameter int unsigned TABLE_DEPTH    = efd_pkg::TableDepthDefault,
  parameter int unsigned CLEANUP_PERIOD = efd_pkg::CleanupPeriodDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire efd_pkg::efd_cmd_t            cmd_i,
  output efd_pkg::efd_sts_t                 sts_o,
  input  wire logic                         kind_i,
  input  wire logic [31:0]                  timestamp_ms_i,
  input  wire logic [2:0]                   instrument_i,
  input  wire logic [31:0]                  t_pred_ms_i,
  input  wire logic [15:0]                  confidence_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [efd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [efd_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                              out_valid_o,
  output logic [2:0]                        out_instrument_o,
  output logic [31:0]                       out_t_pred_ms_o,
  output logic [15:0]                       out_confidence_o,
  output logic                              red_o,
  output logic                              green_o,
  output logic                              blue_o
);
  import efd_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_DEPTH - 1);
  localparam logic [7:0] Period = 8'(CLEANUP_PERIOD);
  localparam logic [31:0] RecipFive = 32'hCCCC_CCCD;

  // configuration
  logic [15:0]        conf_thr_q;
  logic signed [16:0] min_lat_q, max_lat_q;
  logic [15:0]        dup_win_q;

  // item and time state
  logic        kind_q;
  logic [31:0] ts_q, tp_q, cur_q;
  logic [2:0]  instr_q;
  logic [15:0] conf_q;
  logic [7:0]  fcnt_q, fcnt_inc;

  // key divider
  logic [31:0] half_q;
  logic [28:0] quo_q;
  logic [63:0] prod;

  // table
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [31:0] key_mem  [TABLE_DEPTH];
  logic [31:0] time_mem [TABLE_DEPTH];
  logic [31:0] rd_key_q, rd_time_q;
  logic [IdxW-1:0] idx_q, hit_idx_q, free_idx_q;
  logic        hit_found_q, free_found_q;
  logic [31:0] hit_time_q;
  logic [31:0] key;

  logic signed [33:0] latency;
  logic signed [32:0] diff, age;
  logic        pass, dup, age_out;

  assign fcnt_inc = fcnt_q + 8'd1;
  assign key      = {instr_q, quo_q};
  assign latency  = $signed({2'b00, tp_q}) - $signed({2'b00, cur_q});
  assign pass     = (conf_q >= conf_thr_q) &&
                    (latency >= 34'(min_lat_q)) && (latency <= 34'(max_lat_q));
  assign diff     = $signed({1'b0, tp_q}) - $signed({1'b0, hit_time_q});
  assign dup      = hit_found_q && (diff < $signed({17'b0, dup_win_q}));
  assign age      = $signed({1'b0, cur_q}) - $signed({1'b0, rd_time_q});
  assign age_out  = age > $signed({17'b0, dup_win_q});
  assign prod     = {32'b0, half_q} * {32'b0, RecipFive};

  assign sts_o.is_hit    = kind_q;
  assign sts_o.sweep_due = (fcnt_inc >= Period);
  assign sts_o.pass      = pass;
  assign sts_o.idx_last  = (idx_q == IdxLast);

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q <= 16'd32768;
      min_lat_q  <= 17'sd0;
      max_lat_q  <= 17'sd500;
      dup_win_q  <= 16'd50;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgConfThr: conf_thr_q <= cfg_data_i[15:0];
        CfgMinLat:  min_lat_q  <= $signed(cfg_data_i[16:0]);
        CfgMaxLat:  max_lat_q  <= $signed(cfg_data_i[16:0]);
        CfgDupWin:  dup_win_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // capture item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      ts_q    <= timestamp_ms_i;
      instr_q <= instrument_i;
      tp_q    <= t_pred_ms_i;
      conf_q  <= confidence_i;
    end
  end

  // advance frame time and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      fcnt_q <= '0;
    end else if (cmd_i.frame) begin
      cur_q  <= ts_q;
      fcnt_q <= (fcnt_inc >= Period) ? 8'd0 : fcnt_inc;
    end
  end

  // divide (t_pred + 5) by ten: halve first, then multiply by the reciprocal of five
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      half_q <= {1'b0, tp_q[31:1]} + 32'd2 + {31'b0, tp_q[0]};
    end else if (cmd_i.div_step) begin
      quo_q <= prod[62:34];
    end
  end

  // step the scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // read and write the key and time store
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_key_q  <= key_mem[idx_q];
      rd_time_q <= time_mem[idx_q];
    end
    if (cmd_i.decide && !dup) begin
      if (hit_found_q) begin
        time_mem[hit_idx_q] <= tp_q;
      end else if (free_found_q) begin
        key_mem[free_idx_q]  <= key;
        time_mem[free_idx_q] <= tp_q;
      end
    end
  end

  // track first matching entry and first free entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.cmp_hit) begin
      if (valid_q[idx_q]) begin
        if (!hit_found_q && (rd_key_q == key)) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= idx_q;
          hit_time_q  <= rd_time_q;
        end
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
    end
  end

  // set valid on a new entry, drop stale entries during a sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.cmp_sweep) begin
      if (valid_q[idx_q] && age_out) begin
        valid_q[idx_q] <= 1'b0;
      end
    end else if (cmd_i.decide && !dup && !hit_found_q && free_found_q) begin
      valid_q[free_idx_q] <= 1'b1;
    end
  end

  // emit passing kick hits for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= cmd_i.decide && !dup && (instr_q == InstrKick);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      out_instrument_o <= instr_q;
      out_t_pred_ms_o  <= tp_q;
      out_confidence_o <= conf_q;
      red_o            <= (instr_q == InstrKick);
      green_o          <= (instr_q == InstrSnare);
      blue_o           <= (instr_q > InstrSnare);
    end
  end

endmodule
`default_nettype wire

>>> rtl/event_filter_dedup.sv
`default_nettype none
// Filters predicted drum hits by confidence and latency, suppresses repeats of
// the same instrument and 10 ms slot within the duplicate window, and tracks
// them in an event table. Only kick hits produce a result, which shows on the
// out ports for one cycle with out_valid_o; the receiver cannot stall it, so
// it must take it then. An item is taken when start_i is high and busy_o low.
// A frame start also sweeps the whole table for expired entries on each
// CLEANUP_PERIOD-th one. A hit that fails the filter ends after the check; a
// passing hit goes on to the reciprocal multiply that forms its key, then a
// read and a compare per table entry on the single store port, then a decide.
// out_valid_o rises at the same edge at which busy_o falls. cfg_ready_o is
// always high.
module event_filter_dedup #(
  parameter int unsigned TABLE_DEPTH    = efd_pkg::TableDepthDefault,
  parameter int unsigned CLEANUP_PERIOD = efd_pkg::CleanupPeriodDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         kind_i,
  input  wire logic [31:0]                  timestamp_ms_i,
  input  wire logic [2:0]                   instrument_i,
  input  wire logic [31:0]                  t_pred_ms_i,
  input  wire logic [15:0]                  confidence_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [efd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [efd_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                              out_valid_o,
  output logic [2:0]                        out_instrument_o,
  output logic [31:0]                       out_t_pred_ms_o,
  output logic [15:0]                       out_confidence_o,
  output logic                              red_o,
  output logic                              green_o,
  output logic                              blue_o
);
  import efd_pkg::*;

  efd_cmd_t cmd;
  efd_sts_t sts;
  logic     busy;

  assign busy_o      = busy;
  assign cfg_ready_o = 1'b1;

  efd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  efd_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .CLEANUP_PERIOD (CLEANUP_PERIOD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .timestamp_ms_i   (timestamp_ms_i),
    .instrument_i     (instrument_i),
    .t_pred_ms_i      (t_pred_ms_i),
    .confidence_i     (confidence_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_instrument_o (out_instrument_o),
    .out_t_pred_ms_o  (out_t_pred_ms_o),
    .out_confidence_o (out_confidence_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o)
  );

endmodule
`default_nettype wire

>>> verif/tb_event_filter_dedup.sv
`timescale 1ns / 1ps

module tb_event_filter_dedup;
  import efd_pkg::*;

  localparam int unsigned Depth     = TableDepthDefault;
  localparam int unsigned Period    = CleanupPeriodDefault;
  localparam int unsigned CycleCap  = 1500000;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [2:0]  instrument;
    logic [31:0] t_pred;
    logic [15:0] confidence;
    logic        red;
    logic        green;
    logic        blue;
  } kick_cmd_t;

  // Hit filter model: holds its own registers, time base and event table
  class hit_scoreboard;
    logic [15:0]    conf_thr;
    logic signed [16:0] min_lat;
    logic signed [16:0] max_lat;
    logic [15:0]    dup_win;
    logic [31:0]    now_ms;
    logic [7:0]     frames;
    bit             valid[Depth];
    logic [31:0]    keys[Depth];
    logic [31:0]    stamps[Depth];
    kick_cmd_t      pending[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    sweeps;

    function void clear();
      conf_thr = 16'd32768;
      min_lat  = 17'sd0;
      max_lat  = 17'sd500;
      dup_win  = 16'd50;
      now_ms   = '0;
      frames   = '0;
      foreach (valid[i]) valid[i] = 1'b0;
      pending.delete();
      mismatches = 0;
      checked    = 0;
      sweeps     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgConfThr: conf_thr = data[15:0];
        CfgMinLat:  min_lat  = data[16:0];
        CfgMaxLat:  max_lat  = data[16:0];
        CfgDupWin:  dup_win  = data[15:0];
        default: ;
      endcase
    endfunction

    // Note one accepted input beat and queue the kick command it causes
    function void note_item(logic kind, logic [31:0] ts, logic [2:0] instr,
                            logic [31:0] tp, logic [15:0] conf);
      longint    lat;
      longint    diff;
      logic [31:0] key;
      int        hit_idx;
      int        free_idx;
      kick_cmd_t cmd;
      hit_idx  = -1;
      free_idx = -1;
      if (!kind) begin
        now_ms = ts;
        frames = frames + 8'd1;
        if (frames >= Period) begin
          sweeps++;
          for (int i = 0; i < Depth; i++)
            if (valid[i] && (longint'(now_ms) - longint'(stamps[i]) > longint'(dup_win)))
              valid[i] = 1'b0;
          frames = '0;
        end
        return;
      end
      if (conf < conf_thr) return;
      lat = longint'(tp) - longint'(now_ms);
      if (lat < longint'(min_lat) || lat > longint'(max_lat)) return;
      key = {instr, 29'((longint'(tp) + 5) / 10)};
      for (int i = 0; i < Depth; i++) begin
        if (valid[i]) begin
          if (hit_idx < 0 && keys[i] == key) hit_idx = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit_idx >= 0) begin
        diff = longint'(tp) - longint'(stamps[hit_idx]);
        if (diff < longint'(dup_win)) return;
        stamps[hit_idx] = tp;
      end else if (free_idx >= 0) begin
        valid[free_idx]  = 1'b1;
        keys[free_idx]   = key;
        stamps[free_idx] = tp;
      end
      if (instr != InstrKick) return;
      cmd.instrument = instr;
      cmd.t_pred     = tp;
      cmd.confidence = conf;
      cmd.red        = 1'b1;
      cmd.green      = 1'b0;
      cmd.blue       = 1'b0;
      pending.insert(pending.size(), cmd);
    endfunction

    // Compare one emitted command with the oldest expected one
    function void check_result(kick_cmd_t got);
      kick_cmd_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("unexpected command: instr %0d t_pred %0d conf %0d",
                   got.instrument, got.t_pred, got.confidence);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("command mismatch: want i%0d t%0d c%0d rgb%b%b%b got i%0d t%0d c%0d rgb%b%b%b",
                   want.instrument, want.t_pred, want.confidence,
                   want.red, want.green, want.blue,
                   got.instrument, got.t_pred, got.confidence,
                   got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                kind_i = 1'b0;
  logic [31:0]         timestamp_ms_i = '0;
  logic [2:0]          instrument_i = '0;
  logic [31:0]         t_pred_ms_i = '0;
  logic [15:0]         confidence_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                busy_o;
  logic                cfg_ready_o;
  logic                out_valid_o;
  logic [2:0]          out_instrument_o;
  logic [31:0]         out_t_pred_ms_o;
  logic [15:0]         out_confidence_o;
  logic                red_o;
  logic                green_o;
  logic                blue_o;

  hit_scoreboard sb = new();
  int unsigned   cycles;
  int unsigned   items_sent;
  logic [31:0]   cur_ms;
  logic [31:0]   last_tp;

  event_filter_dedup DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .kind_i, .timestamp_ms_i, .instrument_i,
    .t_pred_ms_i, .confidence_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .out_valid_o, .out_instrument_o, .out_t_pred_ms_o,
    .out_confidence_o, .red_o, .green_o, .blue_o
  );

  always #5 clk_i = ~clk_i;

  // Capture every strobed command
  always @(posedge clk_i) begin
    kick_cmd_t got;
    if (rst_ni && out_valid_o) begin
      got.instrument = out_instrument_o;
      got.t_pred     = out_t_pred_ms_o;
      got.confidence = out_confidence_o;
      got.red        = red_o;
      got.green      = green_o;
      got.blue       = blue_o;
      sb.check_result(got);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat; start stays high across back-to-back beats
  task automatic send_item(logic kind, logic [31:0] ts, logic [2:0] instr,
                           logic [31:0] tp, logic [15:0] conf);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    kind_i         <= kind;
    timestamp_ms_i <= ts;
    instrument_i   <= instr;
    t_pred_ms_i    <= tp;
    confidence_i   <= conf;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(kind, ts, instr, tp, conf);
    items_sent++;
  endtask

  task automatic send_frame(logic [31:0] ts);
    send_item(1'b0, ts, 3'($urandom), $urandom, 16'($urandom));
    cur_ms = ts;
  endtask

  task automatic send_hit(logic [2:0] instr, logic [31:0] tp, logic [15:0] conf);
    send_item(1'b1, $urandom, instr, tp, conf);
    last_tp = tp;
  endtask

  // Drain the block so registers can be written safely
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || sb.pending.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(logic [15:0] thr, logic [16:0] lo, logic [16:0] hi,
                           logic [15:0] win);
    settle();
    write_reg(CfgConfThr, {16'($urandom), thr});
    write_reg(CfgMinLat, {15'($urandom), lo});
    write_reg(CfgMaxLat, {15'($urandom), hi});
    write_reg(CfgDupWin, {16'($urandom), win});
  endtask

  task automatic random_item();
    int unsigned r;
    logic [2:0]  instr;
    logic [31:0] tp;
    logic [15:0] conf;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_frame($urandom);
    end else if (r < 15) begin
      send_frame(cur_ms + $urandom_range(0, 60));
    end else if (r < 25) begin
      send_item(1'($urandom), $urandom, 3'($urandom), $urandom, 16'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      instr = (r < 60) ? InstrKick : (r < 75) ? InstrSnare : 3'($urandom_range(2, 7));
      if ($urandom_range(0, 3) == 0) tp = last_tp + $urandom_range(0, 60);
      else tp = cur_ms + $urandom_range(0, 600) - 50;
      conf = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF - 16'($urandom_range(0, 255));
      send_hit(instr, tp, conf);
    end
  endtask

  initial begin
    cycles = 0;
    items_sent = 0;
    cur_ms = '0;
    last_tp = '0;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: hit before any frame, threshold edges, instruments, repeats
    send_hit(InstrKick, 32'd100, 16'hFFFF);
    send_hit(InstrKick, 32'd100, 16'hFFFF);
    send_hit(InstrKick, 32'd160, 16'd32768);
    send_hit(InstrKick, 32'd300, 16'd32767);
    send_hit(InstrKick, 32'd0, 16'd0);
    send_hit(InstrSnare, 32'd200, 16'hFFFF);
    send_hit(3'd7, 32'd250, 16'hFFFF);
    send_hit(InstrKick, 32'd500, 16'hFFFF);
    send_hit(InstrKick, 32'd501, 16'hFFFF);
    send_frame(32'hFFFF_FFFF);
    send_hit(InstrKick, 32'hFFFF_FFFF, 16'hFFFF);
    send_hit(InstrKick, 32'd0, 16'hFFFF);
    for (int i = 0; i < Period; i++) send_frame(32'd1000 + 32'(i * 20));
    send_hit(InstrKick, cur_ms + 32'd5, 16'hFFFF);

    // Register extremes, inverted bounds, then ignored indexes
    write_all(16'd0, 17'h10000, 17'h0FFFF, 16'd0);
    send_hit(InstrKick, 32'd0, 16'd0);
    send_hit(InstrKick, 32'd0, 16'd0);
    send_hit(InstrKick, 32'hFFFF_FFFF, 16'd1);
    write_all(16'hFFFF, 17'd100, 17'd10, 16'hFFFF);
    send_hit(InstrKick, cur_ms + 32'd50, 16'hFFFF);
    settle();
    write_reg(8'd4, $urandom);
    write_reg(8'hFF, $urandom);

    // Fill the table past its depth between sweeps
    write_all(16'd0, 17'h10000, 17'h0FFFF, 16'd50);
    send_frame(32'd100000);
    for (int i = 0; i < Depth + 6; i++)
      send_hit(3'($urandom_range(1, 7)), cur_ms + 32'(i * 10), 16'($urandom));
    for (int i = 0; i < 8; i++)
      send_hit(InstrKick, cur_ms + 32'(i * 10), 16'($urandom));

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_all(16'd32768, 17'd0, 17'd500, 16'd50);
        1: write_all(16'd0, 17'h10000, 17'h0FFFF, 16'd0);
        2: write_all(16'hFFFF, 17'd0, 17'd100, 16'hFFFF);
        3: write_all(16'd40000, 17'h1FFCE, 17'd300, 16'd20);
        default: write_all(16'($urandom_range(0, 65535)), 17'($urandom_range(0, 80)),
                           17'($urandom_range(100, 600)), 16'($urandom_range(0, 120)));
      endcase
      for (int n = 0; n < 75; n++) random_item();
    end

    settle();
    repeat (2 * Depth + 40) @(posedge clk_i);
    $display("%0d input beats sent, %0d kick commands checked, %0d table sweeps",
             items_sent, sb.checked, sb.sweeps);
    $display("six register settings incl. extremes, inverted bounds and a full table");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d commands never seen", sb.mismatches, sb.pending.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
